// ===== design/assert_macros.svh =====
// Assertion macros shared by the hex key parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HKTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hktp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HKTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hktp assertion failed");

`endif

// ===== design/hktp_pkg.sv =====
// Package: constants and types for the hex key text parser.
package hktp_pkg;

    localparam int KEY_BYTES  = 32;
    localparam int HEX_DIGITS = 2 * KEY_BYTES;
    localparam int CNT_W      = $clog2(HEX_DIGITS + 1);
    localparam int POS_W      = 5;
    localparam int LEN_W      = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] REG_BLOB_LENGTH_ADDR = 3'd0;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_LF_HEX = 8'h66;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_UF    = 8'h46;
    localparam logic [7:0] DIGIT_TEN = 8'd10;

    typedef struct packed {
        logic [CNT_W-1:0] count_seen;
        logic [3:0]       upper_nibble;
        logic             parse_failed;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]       key_byte;
        logic [POS_W-1:0] key_position;
        logic             byte_ready;
        logic             blob_done;
        logic             key_ok;
    } parse_result_t;

endpackage

// ===== design/hex_key_text_parser.sv =====
// Top level of the hex key text parser: input register, step logic, result register.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_stall  | blob_byte, final_byte
//  out     | out       | out_valid / out_stall| key_byte, key_position, byte_ready,
//          |           |                      | blob_done, key_ok
//  cfg     | in        | APB psel/penable     | blob_length at byte address 0
//
// One transaction per cycle while out_stall is low; a transaction passes through the input
// register, then the result register, and out_valid rises when it enters the result register.
// Parser state advances when a transaction moves from the input register into
// the result register; out_stall with a full result register holds both registers
// and raises in_stall while the input register is full.
// Reset is asynchronous and active low; it clears blob_length and parser state.
module hex_key_text_parser
    import hktp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         blob_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         key_byte,
    output logic [POS_W-1:0]   key_position,
    output logic               byte_ready,
    output logic               blob_done,
    output logic               key_ok
);

`include "assert_macros.svh"

    logic [LEN_W-1:0] blob_length;
    logic             in_vld_reg;
    logic             in_vld_next;
    logic [7:0]       byte_reg;
    logic             final_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    parse_result_t    res_reg;
    parse_state_t     state_reg;
    parse_state_t     state_next;
    parse_result_t    res_comb;
    logic             accept;
    logic             advance;

    hktp_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .blob_length (blob_length)
    );

    hktp_step u_step (
        .blob_length (blob_length),
        .blob_byte   (byte_reg),
        .final_byte  (final_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (res_comb)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= blob_byte;
            final_reg <= final_byte;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid    = out_vld_reg;
    assign key_byte     = res_reg.key_byte;
    assign key_position = res_reg.key_position;
    assign byte_ready   = res_reg.byte_ready;
    assign blob_done    = res_reg.blob_done;
    assign key_ok       = res_reg.key_ok;

    `HKTP_ASSERT_NOW(a_stall_only_when_full, in_stall, in_vld_reg && out_vld_reg && out_stall)
    `HKTP_ASSERT_NEXT(a_done_clears_state, advance && res_comb.blob_done, state_reg == '0)
    `HKTP_ASSERT_NOW(a_ok_needs_done, out_vld_reg && key_ok, blob_done)
    `HKTP_ASSERT_NOW(a_count_bounded, 1'b1, state_reg.count_seen <= CNT_W'(HEX_DIGITS))
    `HKTP_ASSERT_NEXT(a_stalled_result_held, out_vld_reg && out_stall, out_vld_reg && $stable(res_reg))

endmodule

// ===== design/hktp_apb_regs.sv =====
// APB register block holding the blob length.
module hktp_apb_regs
    import hktp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [LEN_W-1:0]   blob_length
);

    logic [LEN_W-1:0] blob_length_reg;
    logic [LEN_W-1:0] blob_length_next;
    logic             hit;

    // word decode; byte lane bits ignored
    assign hit = (paddr[PADDR_W-1:2] == REG_BLOB_LENGTH_ADDR[PADDR_W-1:2]);

    always_comb
    begin
        blob_length_next = blob_length_reg;
        if (psel && penable && pwrite && hit)
        begin
            blob_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_length_reg <= '0;
        end
        else
        begin
            blob_length_reg <= blob_length_next;
        end
    end

    assign prdata      = hit ? PDATA_W'(blob_length_reg) : '0;
    assign pready      = 1'b1;
    assign blob_length = blob_length_reg;

endmodule

// ===== design/hktp_step.sv =====
// Per-byte decode: hex digit / whitespace classify, raw pass-through and parser state update.
module hktp_step
    import hktp_pkg::*;
(
    input  logic [LEN_W-1:0] blob_length,
    input  logic [7:0]       blob_byte,
    input  logic             final_byte,
    input  parse_state_t     cur,
    output parse_state_t     nxt,
    output parse_result_t    res
);

    logic         raw_mode;
    logic         is_digit;
    logic         is_space;
    logic [7:0]   dval;
    logic [3:0]   digit;
    parse_state_t upd;
    logic [CNT_W-1:0] need;

    assign raw_mode = (blob_length == LEN_W'(KEY_BYTES));

    always_comb
    begin
        dval     = '0;
        is_digit = 1'b1;
        if (blob_byte inside {[CHR_0:CHR_9]})
        begin
            dval = blob_byte - CHR_0;
        end
        else if (blob_byte inside {[CHR_LA:CHR_LF_HEX]})
        begin
            dval = blob_byte - CHR_LA + DIGIT_TEN;
        end
        else if (blob_byte inside {[CHR_UA:CHR_UF]})
        begin
            dval = blob_byte - CHR_UA + DIGIT_TEN;
        end
        else
        begin
            is_digit = 1'b0;
        end
        digit    = dval[3:0];
        is_space = blob_byte inside {CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF};
    end

    always_comb
    begin
        upd              = cur;
        res              = '0;
        if (!cur.parse_failed)
        begin
            if (raw_mode)
            begin
                if (cur.count_seen >= CNT_W'(KEY_BYTES))
                begin
                    upd.parse_failed = 1'b1;
                end
                else
                begin
                    res.key_byte     = blob_byte;
                    res.key_position = cur.count_seen[POS_W-1:0];
                    res.byte_ready   = 1'b1;
                    upd.count_seen   = cur.count_seen + 1'b1;
                end
            end
            else if (!is_digit)
            begin
                if (!is_space)
                begin
                    upd.parse_failed = 1'b1;
                end
            end
            else if (cur.count_seen >= CNT_W'(HEX_DIGITS))
            begin
                upd.parse_failed = 1'b1;
            end
            else
            begin
                if (!cur.count_seen[0])
                begin
                    upd.upper_nibble = digit;
                end
                else
                begin
                    res.key_byte     = {cur.upper_nibble, digit};
                    res.key_position = POS_W'(cur.count_seen >> 1);
                    res.byte_ready   = 1'b1;
                end
                upd.count_seen = cur.count_seen + 1'b1;
            end
        end

        need = raw_mode ? CNT_W'(KEY_BYTES) : CNT_W'(HEX_DIGITS);
        nxt  = upd;
        if (final_byte)
        begin
            res.blob_done = 1'b1;
            res.key_ok    = !upd.parse_failed && (upd.count_seen == need);
            nxt           = '0;
        end
    end

endmodule

// ===== tb/hex_key_text_parser_checker.sv =====
// Checker for the hex key text parser: predicts every result and compares it on the output side.
module hex_key_text_parser_checker
    import hktp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         blob_byte,
    input  logic               final_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         key_byte,
    input  logic [POS_W-1:0]   key_position,
    input  logic               byte_ready,
    input  logic               blob_done,
    input  logic               key_ok,
    output int                 mismatches,
    output int                 outstanding
);

    logic [LEN_W-1:0] blob_len;
    logic [6:0]       digits_seen;
    logic [3:0]       high_digit;
    logic             failed;
    parse_result_t    key_results_q[$];
    parse_result_t    oldest;

    // 16 means the byte is no hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= CHR_0 && c <= CHR_9)
            return {1'b0, 4'(c - CHR_0)};
        if (c >= CHR_LA && c <= CHR_LF_HEX)
            return {1'b0, 4'(c - CHR_LA + DIGIT_TEN)};
        if (c >= CHR_UA && c <= CHR_UF)
            return {1'b0, 4'(c - CHR_UA + DIGIT_TEN)};
        return 5'd16;
    endfunction

    function automatic parse_result_t parse_key_byte(input logic [7:0] c, input logic last);
        parse_result_t r;
        logic [4:0]    d;
        logic [6:0]    need;
        r = '0;
        d = digit_of(c);
        if (!failed)
        begin
            if (blob_len == KEY_BYTES)
            begin
                if (digits_seen >= KEY_BYTES)
                    failed = 1'b1;
                else
                begin
                    r.key_byte     = c;
                    r.key_position = digits_seen[4:0];
                    r.byte_ready   = 1'b1;
                    digits_seen++;
                end
            end
            else if (d[4])
            begin
                if (c != CHR_SPACE && c != CHR_TAB && c != CHR_CR && c != CHR_LF)
                    failed = 1'b1;
            end
            else if (digits_seen >= HEX_DIGITS)
                failed = 1'b1;
            else
            begin
                if (!digits_seen[0])
                    high_digit = d[3:0];
                else
                begin
                    r.key_byte     = {high_digit, d[3:0]};
                    r.key_position = digits_seen[5:1];
                    r.byte_ready   = 1'b1;
                end
                digits_seen++;
            end
        end
        if (last)
        begin
            need        = (blob_len == KEY_BYTES) ? 7'(KEY_BYTES) : 7'(HEX_DIGITS);
            r.blob_done = 1'b1;
            r.key_ok    = !failed && digits_seen == need;
            digits_seen = '0;
            high_digit  = '0;
            failed      = 1'b0;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_len    = '0;
            digits_seen = '0;
            high_digit  = '0;
            failed      = 1'b0;
            mismatches  = 0;
            outstanding = 0;
            key_results_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (key_results_q.size() == 0)
                    note_mismatch("transaction with nothing pending", int'(key_byte), 0);
                else
                begin
                    oldest = key_results_q.pop_front();
                    if (key_byte !== oldest.key_byte)
                        note_mismatch("key_byte", int'(key_byte), int'(oldest.key_byte));
                    if (key_position !== oldest.key_position)
                        note_mismatch("key_position", int'(key_position),
                                      int'(oldest.key_position));
                    if (byte_ready !== oldest.byte_ready)
                        note_mismatch("byte_ready", int'(byte_ready), int'(oldest.byte_ready));
                    if (blob_done !== oldest.blob_done)
                        note_mismatch("blob_done", int'(blob_done), int'(oldest.blob_done));
                    if (key_ok !== oldest.key_ok)
                        note_mismatch("key_ok", int'(key_ok), int'(oldest.key_ok));
                end
            end
            if (psel && penable && pwrite && pready && paddr == REG_BLOB_LENGTH_ADDR)
                blob_len = pwdata[LEN_W-1:0];
            if (in_valid && !in_stall)
                key_results_q.push_back(parse_key_byte(blob_byte, final_byte));
            outstanding = key_results_q.size();
        end
    end

endmodule

// ===== tb/hex_key_text_parser_tb.sv =====
// Testbench top for the hex key text parser: clock, reset, stimulus, APB writes and verdict.
module hex_key_text_parser_tb;
    import hktp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_SETTING = 160;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         blob_byte;
    logic               final_byte;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         key_byte;
    logic [POS_W-1:0]   key_position;
    logic               byte_ready;
    logic               blob_done;
    logic               key_ok;

    int mismatches;
    int outstanding;
    int send_pct;
    int recv_pct;
    int cycles = 0;

    logic [7:0]       blob_q[$];
    logic [LEN_W-1:0] blob_len;
    logic [7:0]       bad_char;
    int               kind;
    int               n_digits;
    int               bad_pos;
    int               sent;

    hex_key_text_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .blob_byte    (blob_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_byte     (key_byte),
        .key_position (key_position),
        .byte_ready   (byte_ready),
        .blob_done    (blob_done),
        .key_ok       (key_ok)
    );

    hex_key_text_parser_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .blob_byte    (blob_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_byte     (key_byte),
        .key_position (key_position),
        .byte_ready   (byte_ready),
        .blob_done    (blob_done),
        .key_ok       (key_ok),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = (int'($urandom_range(99)) < recv_pct);
        end
    end

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < DIGIT_TEN)
            return CHR_0 + 8'(v);
        return (upper ? CHR_UA : CHR_LA) + 8'(v) - DIGIT_TEN;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0: return CHR_SPACE;
            1: return CHR_TAB;
            2: return CHR_CR;
            default: return CHR_LF;
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic last);
        while (int'($urandom_range(99)) < send_pct)
            @(negedge clk);
        in_valid   = 1'b1;
        blob_byte  = b;
        final_byte = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = a;
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        blob_byte  = '0;
        final_byte = 1'b0;
        send_pct   = 0;
        recv_pct   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // hex mode from reset: digits of both cases, blanks, bad characters
        send_item(CHR_0, 1'b0);
        send_item(CHR_9, 1'b0);
        send_item(CHR_LA, 1'b0);
        send_item(CHR_UF, 1'b0);
        send_item(CHR_SPACE, 1'b0);
        send_item(CHR_TAB, 1'b0);
        send_item(CHR_CR, 1'b0);
        send_item(CHR_LF, 1'b0);
        send_item(CHR_LF_HEX, 1'b0);
        send_item(CHR_UA, 1'b0);
        send_item(CHR_9, 1'b0);
        send_item(8'h47, 1'b0);
        send_item(CHR_0, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        drain();
        // raw pass-through, short blob
        apb_write(REG_BLOB_LENGTH_ADDR, PDATA_W'(KEY_BYTES));
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_pct = 12;
                    recv_pct = 82;
                end
                1:
                begin
                    send_pct = 82;
                    recv_pct = 12;
                end
                default:
                begin
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            for (int k = 0; k < 3; k++)
            begin
                case (ph * 3 + k)
                    0, 8: blob_len = '0;
                    1, 3, 7: blob_len = LEN_W'(KEY_BYTES);
                    2: blob_len = '1;
                    4: blob_len = LEN_W'($urandom_range(65535));
                    5: blob_len = LEN_W'(KEY_BYTES + 1);
                    default: blob_len = LEN_W'(KEY_BYTES - 1);
                endcase
                drain();
                apb_write(REG_BLOB_LENGTH_ADDR, PDATA_W'(blob_len));
                sent = 0;
                while (sent < ITEMS_PER_SETTING)
                begin
                    blob_q.delete();
                    kind = int'($urandom_range(99));
                    if (blob_len == KEY_BYTES)
                    begin
                        n_digits = kind < 60 ? KEY_BYTES :
                                   kind < 75 ? int'($urandom_range(KEY_BYTES - 1, 1)) :
                                   kind < 90 ? int'($urandom_range(KEY_BYTES + 8, KEY_BYTES + 1))
                                             : 1;
                        repeat (n_digits) blob_q.push_back(8'($urandom_range(255)));
                    end
                    else if (kind >= 88)
                        repeat ($urandom_range(20, 1)) blob_q.push_back(8'($urandom_range(255)));
                    else
                    begin
                        n_digits = kind < 60 ? HEX_DIGITS :
                                   kind < 70 ? int'($urandom_range(HEX_DIGITS - 1, 1)) :
                                   kind < 78 ? int'($urandom_range(HEX_DIGITS + 16,
                                                                   HEX_DIGITS + 1)) :
                                   HEX_DIGITS;
                        bad_pos = kind >= 78 ? int'($urandom_range(n_digits - 1)) : -1;
                        for (int i = 0; i < n_digits; i++)
                        begin
                            if (i == bad_pos)
                            begin
                                bad_char = CHR_LF_HEX + 8'd1
                                           + 8'($urandom_range(8'hFF - CHR_LF_HEX - 1));
                                blob_q.push_back(bad_char);
                            end
                            if ($urandom_range(7) == 0)
                                blob_q.push_back(blank_char());
                            blob_q.push_back(hex_char(int'($urandom_range(15)),
                                                      1'($urandom_range(1))));
                        end
                        if ($urandom_range(3) == 0)
                            blob_q.push_back(blank_char());
                    end
                    foreach (blob_q[i])
                        send_item(blob_q[i], i == blob_q.size() - 1);
                    sent += blob_q.size();
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
